// ===== hw/rtl/ipck_pkg.sv =====
// Shared types, constants and ones'-complement helpers of the checksum engine.
package ipck_pkg;

  localparam int unsigned SumW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatW    = 2;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // IP header geometry
  localparam logic [SumW-1:0] Ipv4HdrLen = 16'd20;
  localparam logic [SumW-1:0] Ipv6HdrLen = 16'd40;
  localparam logic [SumW-1:0] Ipv4SrcPos = 16'd12;
  localparam logic [SumW-1:0] Ipv6SrcPos = 16'd8;
  localparam logic [SumW-1:0] PosMax     = 16'hffff;
  localparam logic [SumW-1:0] PosLastPad = 16'hfffe;
  localparam logic [SumW-1:0] SumZeroSubst = 16'hffff;

  // Length field byte positions
  localparam logic [SumW-1:0] Ipv4LenHiPos = 16'd2;
  localparam logic [SumW-1:0] Ipv4LenLoPos = 16'd3;
  localparam logic [SumW-1:0] Ipv6LenHiPos = 16'd4;
  localparam logic [SumW-1:0] Ipv6LenLoPos = 16'd5;

  // Decoupling queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] ProtoReset = 8'd6;

  typedef enum logic [0:0] {
    REG_IP_VERSION_MODE    = 1'b0,
    REG_TRANSPORT_PROTOCOL = 1'b1
  } ipck_reg_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_SHORT  = 2'd1,
    STAT_LONG   = 2'd2,
    STAT_BADLEN = 2'd3
  } ipck_status_e;

  typedef struct packed {
    logic             v6;
    logic [ByteW-1:0] proto;
  } ipck_cfg_t;

  // One classified byte, as the back end consumes it
  typedef struct packed {
    logic             hdr_en;
    logic [SumW-1:0]  hdr_word;
    logic             ts_en;
    logic [SumW-1:0]  ts_word;
    logic             eop;
    logic             v6;
    logic [SumW-1:0]  pseudo;
    ipck_status_e     status;
  } ipck_entry_t;

  // Two-operand add with end-around carry
  function automatic logic [SumW-1:0] oc_add(input logic [SumW-1:0] a,
                                             input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
  endfunction

  // Three-operand add with end-around carry, same result as two chained adds
  function automatic logic [SumW-1:0] oc_add3(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b,
                                              input logic [SumW-1:0] c);
    logic [SumW+1:0] s;
    logic [SumW:0]   t;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    t = {1'b0, s[SumW-1:0]} + {{(SumW-1){1'b0}}, s[SumW+1:SumW]};
    return t[SumW-1:0] + {{(SumW-1){1'b0}}, t[SumW]};
  endfunction

  // A zero sum is replaced by all ones, then complemented
  function automatic logic [SumW-1:0] oc_finish(input logic [SumW-1:0] s);
    logic [SumW-1:0] v;
    v = (s == '0) ? SumZeroSubst : s;
    return ~v;
  endfunction

endpackage

// ===== hw/rtl/ipck_if.sv =====
// Valid/ready channel interfaces for packet bytes and checksum results.
interface ipck_in_if;
  import ipck_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packet_byte;
  logic             end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface ipck_out_if;
  import ipck_pkg::*;
  logic             valid;
  logic             ready;
  logic [SumW-1:0]  header_checksum;
  logic [SumW-1:0]  transport_checksum;
  logic [StatW-1:0] packet_status;
  logic             result_last;

  modport source (output valid, output header_checksum, output transport_checksum,
                  output packet_status, output result_last, input ready);
  modport sink   (input valid, input header_checksum, input transport_checksum,
                  input packet_status, input result_last, output ready);
endinterface

// ===== hw/rtl/ipck_front.sv =====
// Front end: tracks byte position and length field, classifies each byte.
module ipck_front
  import ipck_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ipck_cfg_t   cfg_i,
  ipck_in_if.sink     pkt_i,
  output logic        push_o,
  output ipck_entry_t entry_o,
  input  logic        full_i
);

  logic [SumW-1:0]  pos_q, pos_d;
  logic [SumW-1:0]  len_q, len_d;
  logic [ByteW-1:0] held_q, held_d;

  logic             accept;
  logic             proc;
  logic             v6;
  logic [ByteW-1:0] b;
  logic [SumW-1:0]  word;
  logic [SumW-1:0]  hi_word;
  logic [SumW-1:0]  held_word;
  logic [SumW:0]    n_cnt;
  logic [SumW:0]    limit;
  logic [SumW-1:0]  upper;

  // Byte lies in the pseudo-header address span or the declared payload
  function automatic logic in_tp(input logic [SumW-1:0] x, input logic [SumW-1:0] len,
                                 input logic is_v6);
    logic [SumW:0] end6;
    end6 = {1'b0, Ipv6HdrLen} + {1'b0, len};
    if (!is_v6) begin
      return (x >= Ipv4SrcPos && x < Ipv4HdrLen) || (x >= Ipv4HdrLen && x < len);
    end
    return (x >= Ipv6SrcPos && x < Ipv6HdrLen) ||
           (x >= Ipv6HdrLen && {1'b0, x} < end6);
  endfunction

  assign pkt_i.ready = !full_i;
  assign accept      = pkt_i.valid && !full_i;
  assign push_o      = accept;

  assign v6        = cfg_i.v6;
  assign b         = pkt_i.packet_byte;
  assign proc      = (pos_q != PosMax);
  assign word      = {held_q, b};
  assign hi_word   = {b, {ByteW{1'b0}}};
  assign held_word = {held_q, {ByteW{1'b0}}};

  // Length field capture
  always_comb begin
    len_d = len_q;
    if (proc && !v6 && pos_q == Ipv4LenHiPos) len_d[SumW-1:ByteW] = b;
    if (proc && !v6 && pos_q == Ipv4LenLoPos) len_d[ByteW-1:0]    = b;
    if (proc &&  v6 && pos_q == Ipv6LenHiPos) len_d[SumW-1:ByteW] = b;
    if (proc &&  v6 && pos_q == Ipv6LenLoPos) len_d[ByteW-1:0]    = b;
  end

  // Pseudo-header length plus protocol, and length status
  assign upper = v6 ? len_d : (len_d - Ipv4HdrLen);
  assign n_cnt = proc ? ({1'b0, pos_q} + 17'd1) : {1'b0, PosMax};
  assign limit = v6 ? ({1'b0, Ipv6HdrLen} + {1'b0, len_d}) : {1'b0, len_d};

  // Classification into header and transport adds, plus end-of-packet fields
  always_comb begin
    entry_o.hdr_en   = 1'b0;
    entry_o.hdr_word = word;
    entry_o.ts_en    = 1'b0;
    entry_o.ts_word  = word;
    if (proc && !v6 && pos_q < Ipv4HdrLen) begin
      if (pos_q[0]) begin
        entry_o.hdr_en = 1'b1;
      end else if (pkt_i.end_of_packet) begin
        entry_o.hdr_en   = 1'b1;
        entry_o.hdr_word = hi_word;
      end
    end
    if (proc) begin
      if (in_tp(pos_q, len_q, v6)) begin
        if (pos_q[0]) begin
          entry_o.ts_en = 1'b1;
        end else if (pkt_i.end_of_packet) begin
          entry_o.ts_en   = 1'b1;
          entry_o.ts_word = hi_word;
        end
      end else if (pos_q[0] && in_tp(pos_q - 16'd1, len_q, v6)) begin
        entry_o.ts_en   = 1'b1;
        entry_o.ts_word = held_word;
      end
    end else if (pkt_i.end_of_packet && in_tp(PosLastPad, len_q, v6)) begin
      // saturated packet: trailing even byte pad
      entry_o.ts_en   = 1'b1;
      entry_o.ts_word = held_word;
    end

    entry_o.eop    = pkt_i.end_of_packet;
    entry_o.v6     = v6;
    entry_o.pseudo = oc_add(upper, {{(SumW-ByteW){1'b0}}, cfg_i.proto});
    if (!v6 && len_d < Ipv4HdrLen) begin
      entry_o.status = STAT_BADLEN;
    end else if (n_cnt < limit) begin
      entry_o.status = STAT_SHORT;
    end else if (n_cnt > limit) begin
      entry_o.status = STAT_LONG;
    end else begin
      entry_o.status = STAT_OK;
    end
  end

  // Packet state advance, cleared at end of packet
  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    if (proc) begin
      pos_d = pos_q + 16'd1;
      if (!pos_q[0]) held_d = b;
    end
    if (pkt_i.end_of_packet) begin
      pos_d  = '0;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      held_q <= held_d;
      len_q  <= pkt_i.end_of_packet ? '0 : len_d;
    end
  end

endmodule

// ===== hw/rtl/ipck_queue.sv =====
// Short FIFO of classified bytes between front and back end.
module ipck_queue
  import ipck_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ipck_entry_t entry_i,
  output logic        full_o,
  output logic        valid_o,
  output ipck_entry_t entry_o,
  input  logic        pop_i
);

  ipck_entry_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ipck_back.sv =====
// Back end: runs both ones'-complement sums and registers the result.
module ipck_back
  import ipck_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  ipck_entry_t entry_i,
  output logic        pop_o,
  ipck_out_if.source  res_o
);

  logic [SumW-1:0]  hs_q, ts_q;
  logic [SumW-1:0]  hs_new, ts_new;
  logic             out_valid_q;
  logic [SumW-1:0]  hdr_ck_q, ts_ck_q;
  ipck_status_e     status_q;
  logic             slot_free;

  // End-of-packet entries wait for a free result slot
  assign slot_free = !out_valid_q || res_o.ready;
  assign pop_o     = valid_i && (!entry_i.eop || slot_free);

  assign hs_new = oc_add(hs_q, entry_i.hdr_en ? entry_i.hdr_word : '0);
  assign ts_new = oc_add3(ts_q, entry_i.ts_en ? entry_i.ts_word : '0,
                          entry_i.eop ? entry_i.pseudo : '0);

  // Accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= '0;
      ts_q <= '0;
    end else if (pop_o) begin
      hs_q <= entry_i.eop ? '0 : hs_new;
      ts_q <= entry_i.eop ? '0 : ts_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && entry_i.eop) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.eop) begin
      hdr_ck_q <= entry_i.v6 ? '0 : oc_finish(hs_new);
      ts_ck_q  <= oc_finish(ts_new);
      status_q <= entry_i.status;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.header_checksum    = hdr_ck_q;
  assign res_o.transport_checksum = ts_ck_q;
  assign res_o.packet_status      = status_q;
  assign res_o.result_last        = 1'b1;

endmodule

// ===== hw/rtl/ip_transport_checksum_engine.sv =====
// Top level of the IP header and transport checksum engine.
//
// Packet bytes arrive on pkt_i (valid/ready), one per cycle, in wire order
// starting at the IP header; end_of_packet marks the last byte. One result
// per packet leaves on res_o: the complemented IPv4 header sum (zero in IPv6
// mode), the complemented pseudo-header plus payload sum, a length status
// and result_last, always high.
// Throughput is one byte per cycle while the queue is not full; each byte
// feeds both 16-bit end-around sums in the back end. An end-of-packet
// byte goes through the two-entry queue, then into the result register.
// The APB port holds ip_version_mode at 0x0 and transport_protocol at 0x4;
// write them only between packets. pready is tied high.
// Reset clears the packet state, the queue, the sums and the result valid flag; the
// mode register resets to IPv4 and the protocol to 6.
// While res_o is stalled the front keeps taking bytes into the queue; an
// end-of-packet entry waits at the queue head until the result is taken,
// and pkt_i.ready drops once the queue is full.
module ip_transport_checksum_engine
  import ipck_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  ipck_in_if.sink             pkt_i,
  ipck_out_if.source          res_o
);

  logic        mode_q;
  logic [ByteW-1:0] proto_q;
  ipck_cfg_t   cfg;
  ipck_reg_e   reg_sel;
  logic        cfg_wr;

  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  ipck_entry_t fe_entry;
  ipck_entry_t q_entry;

  // Register file
  assign pready  = 1'b1;
  assign reg_sel = ipck_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      proto_q <= ProtoReset;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_IP_VERSION_MODE:    mode_q  <= pwdata[0];
        REG_TRANSPORT_PROTOCOL: proto_q <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IP_VERSION_MODE:    prdata = {{(ApbDataW-1){1'b0}}, mode_q};
      REG_TRANSPORT_PROTOCOL: prdata = {{(ApbDataW-ByteW){1'b0}}, proto_q};
      default:                prdata = '0;
    endcase
  end

  assign cfg.v6    = mode_q;
  assign cfg.proto = proto_q;

  ipck_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pkt_i   (pkt_i),
    .push_o  (push),
    .entry_o (fe_entry),
    .full_i  (q_full)
  );

  ipck_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (fe_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  ipck_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (q_pop),
    .res_o   (res_o)
  );

endmodule

// ===== hw/rtl/ipck_checker.sv =====
// Port-level assertions for the checksum engine, bound to the top level.
module ipck_assert
  import ipck_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic [ApbAddrW-1:0] paddr,
  input logic [ApbDataW-1:0] prdata,
  input logic                pready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [SumW-1:0]     res_hdr,
  input logic [SumW-1:0]     res_ts,
  input logic [StatW-1:0]    res_status,
  input logic                res_last
);

  // A stalled result holds its value
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_hdr) && $stable(res_ts)
                                && $stable(res_status))
    else $error("result changed while stalled");

  // Every valid result is flagged last
  a_res_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_last)
    else $error("result without result_last");

  // The register port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  // Mode register reads back a single bit, protocol register eight
  a_prdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> (paddr[2] ? (prdata[ApbDataW-1:ByteW] == '0) : (prdata[ApbDataW-1:1] == '0)))
    else $error("unused register bits read nonzero");

endmodule

bind ip_transport_checksum_engine ipck_assert u_ipck_assert (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .psel       (psel),
  .paddr      (paddr),
  .prdata     (prdata),
  .pready     (pready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_hdr    (res_o.header_checksum),
  .res_ts     (res_o.transport_checksum),
  .res_status (res_o.packet_status),
  .res_last   (res_o.result_last)
);
